FILE: design/ept_pkg.sv
package ept_pkg;

  localparam int unsigned IdxBits = 9;

  typedef enum logic {
    REQ_WRITE     = 1'b0,
    REQ_TRANSLATE = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    WS_MAP_4K      = 3'd0,
    WS_MAP_2M      = 3'd1,
    WS_MAP_1G      = 3'd2,
    WS_NOT_PRESENT = 3'd3,
    WS_WRITE_DONE  = 3'd4
  } walk_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } walk_state_e;

  typedef enum logic [1:0] {
    LVL_1 = 2'd0,
    LVL_2 = 2'd1,
    LVL_3 = 2'd2,
    LVL_4 = 2'd3
  } walk_level_e;

  typedef struct packed {
    logic        req_type;
    logic [11:0] word_index;
    logic [63:0] word_data;
    logic [47:0] guest_addr;
  } ept_req_t;

  typedef struct packed {
    logic [51:0]  host_addr;
    walk_status_e walk_status;
    logic [11:0]  entry_word;
  } ept_rsp_t;

  // nine guest address bits that index the table at a given level
  function automatic logic [IdxBits-1:0] level_index(logic [47:0] ga, walk_level_e lvl);
    logic [IdxBits-1:0] idx;
    unique case (lvl)
      LVL_4:   idx = ga[47:39];
      LVL_3:   idx = ga[38:30];
      LVL_2:   idx = ga[29:21];
      default: idx = ga[20:12];
    endcase
    return idx;
  endfunction

endpackage

FILE: design/ept_ifs.sv
interface ept_req_if import ept_pkg::*; ();
  logic     valid;
  logic     ready;
  ept_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ept_rsp_if import ept_pkg::*; ();
  logic     valid;
  logic     ready;
  ept_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/ept_four_level_page_walk_top.sv
// channel   dir  payload                                           handshake
// req_if    in   req_type, word_index, word_data, guest_addr       valid/ready
// rsp_if    out  host_addr, walk_status, entry_word                valid/ready
// cfg       in   root_table_base (cfg_wdata_i)                     cfg_we_i, no ready
//
// one item at a time: a write goes through issue and finish, a translation through
// issue, one read of the table memory per level walked, and finish.
// the registered read of the table memory sets the per-level step.
// reset clears control and root_table_base; table contents are not cleared.
// a result waits in the output register; the next item is taken meanwhile.
// TABLE_WORDS must be a power of two; word indices wrap modulo the depth.
module ept_four_level_page_walk_top import ept_pkg::*; #(
  parameter int unsigned TABLE_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [51:0] cfg_wdata_i,
  ept_req_if.sink     req_if,
  ept_rsp_if.source   rsp_if
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);

  function automatic logic [AW-1:0] word_of(logic [51:0] base, logic [IdxBits-1:0] idx);
    logic [48:0] full;
    full = {base[51:12], idx};
    return full[AW-1:0];
  endfunction

  logic [63:0]   mem_q [TABLE_WORDS];
  logic [63:0]   rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  walk_state_e   state_q, state_d;
  walk_level_e   lvl_q, lvl_d;
  logic [51:0]   root_q;
  logic [47:0]   ga_q, ga_d;
  logic [AW-1:0] w_q, w_d;
  ept_rsp_t      res_q, res_d;
  logic          out_valid_q, out_valid_d;
  ept_rsp_t      out_q, out_d;

  logic [31:0]   wi_ext;
  logic [31:0]   w_ext;
  logic [63:0]   e;
  logic [AW-1:0] next_w;

  assign wi_ext = 32'(req_if.data.word_index);
  assign e      = rd_data_q;

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= req_if.data.word_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= LVL_4;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ga_q  <= ga_d;
    w_q   <= w_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign req_if.ready = (state_q == S_IDLE);
  assign rsp_if.valid = out_valid_q;
  assign rsp_if.data  = out_q;

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    ga_d        = ga_q;
    w_d         = w_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !rsp_if.ready;
    out_d       = out_q;
    rd_addr     = w_q;
    wr_en       = 1'b0;
    wr_addr     = wi_ext[AW-1:0];
    next_w      = word_of(e[51:0], level_index(ga_q, walk_level_e'(lvl_q - 2'd1)));
    w_ext       = 32'(w_q);

    unique case (state_q)
      S_IDLE: begin
        if (req_if.valid) begin
          ga_d = req_if.data.guest_addr;
          if (req_if.data.req_type == REQ_WRITE) begin
            wr_en             = 1'b1;
            res_d.host_addr   = '0;
            res_d.walk_status = WS_WRITE_DONE;
            res_d.entry_word  = wi_ext[11:0] & 12'(TABLE_WORDS - 1);
            state_d           = S_FINISH;
          end else begin
            w_d     = word_of(root_q, level_index(req_if.data.guest_addr, LVL_4));
            rd_addr = w_d;
            lvl_d   = LVL_4;
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        res_d.entry_word = w_ext[11:0];
        res_d.host_addr  = '0;
        if (lvl_q == LVL_1) begin
          // last level is taken without a presence check
          res_d.host_addr   = {e[51:12], ga_q[11:0]};
          res_d.walk_status = WS_MAP_4K;
          state_d           = S_FINISH;
        end else if (e[2:0] == 3'b000) begin
          res_d.walk_status = WS_NOT_PRESENT;
          state_d           = S_FINISH;
        end else if (e[7] && lvl_q == LVL_3) begin
          res_d.host_addr   = {e[51:30], ga_q[29:0]};
          res_d.walk_status = WS_MAP_1G;
          state_d           = S_FINISH;
        end else if (e[7] && lvl_q == LVL_2) begin
          res_d.host_addr   = {e[51:21], ga_q[20:0]};
          res_d.walk_status = WS_MAP_2M;
          state_d           = S_FINISH;
        end else begin
          w_d     = next_w;
          rd_addr = next_w;
          lvl_d   = walk_level_e'(lvl_q - 2'd1);
        end
      end

      S_FINISH: begin
        if (!out_valid_q || rsp_if.ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/ept_walk_checker.sv
module ept_walk_checker import ept_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [51:0] cfg_wdata_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  ept_req_t    req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  ept_rsp_t    rsp_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] tbl_words [4096];
  logic [51:0] root_base;
  ept_rsp_t    pending_rsp_q [$];
  ept_rsp_t    want_rsp;
  int          fails = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  // four-level walk over the shadow tables, level 4 first
  function automatic ept_rsp_t walk_tables(input logic [47:0] ga);
    ept_rsp_t    rsp;
    logic [51:0] base;
    logic [63:0] entry;
    logic [11:0] w;
    int          lvl;
    bit          done;
    base            = root_base;
    done            = 1'b0;
    rsp.host_addr   = '0;
    rsp.walk_status = WS_NOT_PRESENT;
    rsp.entry_word  = '0;
    for (lvl = 3; lvl >= 0 && !done; lvl--) begin
      // table base bits 14..12 pick one of eight 512-word tables
      w              = {base[14:12], ga[12 + 9*lvl +: 9]};
      entry          = tbl_words[w];
      rsp.entry_word = w;
      done           = 1'b1;
      if (lvl > 0 && entry[2:0] == 3'b000) begin
        rsp.host_addr   = '0;
        rsp.walk_status = WS_NOT_PRESENT;
      end else if (lvl == 2 && entry[7]) begin
        rsp.host_addr   = {entry[51:30], ga[29:0]};
        rsp.walk_status = WS_MAP_1G;
      end else if (lvl == 1 && entry[7]) begin
        rsp.host_addr   = {entry[51:21], ga[20:0]};
        rsp.walk_status = WS_MAP_2M;
      end else if (lvl == 0) begin
        rsp.host_addr   = {entry[51:12], ga[11:0]};
        rsp.walk_status = WS_MAP_4K;
      end else begin
        base = entry[51:0];
        done = 1'b0;
      end
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_base = '0;
      pending_rsp_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_we_i) begin
        root_base = cfg_wdata_i;
      end
      if (req_valid_i && req_ready_i) begin
        if (req_data_i.req_type == REQ_WRITE) begin
          tbl_words[req_data_i.word_index] = req_data_i.word_data;
          want_rsp = '{host_addr: '0, walk_status: WS_WRITE_DONE,
                       entry_word: req_data_i.word_index};
        end else begin
          want_rsp = walk_tables(req_data_i.guest_addr);
        end
        pending_rsp_q.push_back(want_rsp);
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_rsp_q.size() == 0) begin
          report("result with nothing outstanding", 64'(rsp_data_i.host_addr), '0);
        end else begin
          want_rsp = pending_rsp_q.pop_front();
          if (rsp_data_i.host_addr !== want_rsp.host_addr) begin
            report("host_addr", 64'(rsp_data_i.host_addr), 64'(want_rsp.host_addr));
          end
          if (rsp_data_i.walk_status !== want_rsp.walk_status) begin
            report("walk_status", 64'(rsp_data_i.walk_status), 64'(want_rsp.walk_status));
          end
          if (rsp_data_i.entry_word !== want_rsp.entry_word) begin
            report("entry_word", 64'(rsp_data_i.entry_word), 64'(want_rsp.entry_word));
          end
        end
      end
      pending_o    <= pending_rsp_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: tb/ept_four_level_page_walk_top_tb.sv
module ept_four_level_page_walk_top_tb import ept_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    END_TABLE,
    END_LARGE,
    END_ABSENT
  } walk_end_e;

  localparam logic [51:0] RootMax = 52'hF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [51:0] cfg_wdata;
  int          fail_count;
  int          pending;

  ept_req_if req_if ();
  ept_rsp_if rsp_if ();

  logic [63:0] shadow_mem [4096];
  bit          shadow_set [4096];
  logic [51:0] root_shadow;
  logic [47:0] recent_ga_q [$];

  int send_idle_pct = 36;
  int rcv_idle_pct  = 77;
  int items_sent    = 0;
  int writes_sent   = 0;
  int walks_sent    = 0;
  int root_settings = 0;
  int phase_target;

  ept_four_level_page_walk_top #(
    .TABLE_WORDS(4096)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_if     (req_if),
    .rsp_if     (rsp_if)
  );

  ept_walk_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_data_i  (req_if.data),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_data_i  (rsp_if.data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic send_item(input ept_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic ept_req_t junk_item();
    ept_req_t item;
    item.req_type   = REQ_TRANSLATE;
    item.word_index = 12'($urandom);
    item.word_data  = {$urandom, $urandom};
    item.guest_addr = 48'({$urandom, $urandom});
    return item;
  endfunction

  task automatic write_word(input logic [11:0] w, input logic [63:0] data);
    ept_req_t item;
    item            = junk_item();
    item.req_type   = REQ_WRITE;
    item.word_index = w;
    item.word_data  = data;
    shadow_mem[w]   = data;
    shadow_set[w]   = 1'b1;
    send_item(item);
    writes_sent++;
  endtask

  function automatic logic [63:0] make_entry(input int lvl, input bit last, input walk_end_e kind);
    logic [63:0] e;
    e = {$urandom, $urandom};
    if (last && kind == END_ABSENT) begin
      // also clears rwx at level 1, which the walk must not check
      e[2:0] = 3'b000;
    end else if (last && kind == END_LARGE) begin
      e[2:0] = 3'($urandom_range(1, 7));
      e[7]   = 1'b1;
    end else if (lvl > 1) begin
      e[2:0] = 3'($urandom_range(1, 7));
      // the large-page bit means nothing at level 4
      if (lvl != 4) e[7] = 1'b0;
    end
    return e;
  endfunction

  // fill in whatever entries the walk would touch, then send the translation
  task automatic run_walk(input logic [47:0] ga, input int end_lvl, input walk_end_e kind,
                          input bit rewrite);
    logic [51:0] base;
    logic [11:0] w;
    logic [63:0] entry;
    ept_req_t    item;
    int          lvl;
    bit          done;
    bit          seen_w [logic [11:0]];
    base = root_shadow;
    done = 1'b0;
    for (lvl = 4; lvl >= 1 && !done; lvl--) begin
      w = {base[14:12], ga[12 + 9*(lvl-1) +: 9]};
      // a word already on this path keeps its entry so the path stays as built
      if ((rewrite && !seen_w.exists(w)) || !shadow_set[w]) begin
        write_word(w, make_entry(lvl, lvl == end_lvl, kind));
      end
      seen_w[w] = 1'b1;
      entry = shadow_mem[w];
      if (lvl > 1 && entry[2:0] == 3'b000) done = 1'b1;
      else if ((lvl == 3 || lvl == 2) && entry[7]) done = 1'b1;
      base = entry[51:0];
    end
    item            = junk_item();
    item.req_type   = REQ_TRANSLATE;
    item.guest_addr = ga;
    send_item(item);
    walks_sent++;
  endtask

  task automatic drain_all(input int tail);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_root(input logic [51:0] v);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    root_shadow = v;
    root_settings++;
  endtask

  task automatic random_traffic(input int count);
    logic [47:0] ga;
    phase_target = items_sent + count;
    while (items_sent < phase_target) begin
      if ($urandom_range(99) < 15) begin
        write_word(12'($urandom), {$urandom, $urandom});
      end else begin
        if (recent_ga_q.size() > 0 && $urandom_range(99) < 30) begin
          // revisit a known region so existing tables get reused
          ga       = recent_ga_q[$urandom_range(recent_ga_q.size() - 1)];
          ga[20:0] = 21'($urandom);
        end else begin
          ga = 48'({$urandom, $urandom});
        end
        recent_ga_q.push_back(ga);
        if (recent_ga_q.size() > 64) void'(recent_ga_q.pop_front());
        run_walk(ga, $urandom_range(1, 4), walk_end_e'($urandom_range(0, 2)),
                 $urandom_range(99) < 10);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    root_shadow  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_root(RootMax);
    write_word(12'h000, 64'h0);
    write_word(12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    run_walk(48'h0, 1, END_TABLE, 1'b1);
    run_walk(48'hFFFF_FFFF_FFFF, 3, END_LARGE, 1'b1);
    run_walk(48'({$urandom, $urandom}), 2, END_LARGE, 1'b1);
    run_walk(48'({$urandom, $urandom}), 4, END_ABSENT, 1'b1);
    run_walk(48'({$urandom, $urandom}), 3, END_ABSENT, 1'b1);
    run_walk(48'({$urandom, $urandom}), 2, END_ABSENT, 1'b1);
    run_walk(48'({$urandom, $urandom}), 1, END_ABSENT, 1'b1);

    drain_all(10);
    set_root('0);
    random_traffic(275);

    drain_all(10);
    send_idle_pct = 77;
    rcv_idle_pct  = 36;
    set_root(52'({$urandom, $urandom}));
    random_traffic(275);

    drain_all(10);
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    set_root(52'({$urandom, $urandom}));
    random_traffic(275);

    drain_all(20);
    $display("covered %0d items (%0d table writes, %0d walks) under %0d root table settings",
             items_sent, writes_sent, walks_sent, root_settings);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
